### src/png_hdr_pkg.sv
// ----------------------------------------------------------------------------
// PNG header parser package
// Request types and fixed constants shared by the PNG header size parser and its bench.
// ----------------------------------------------------------------------------
package png_hdr_pkg;

    // One byte of the incoming file.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    // One parse result, given once per file.
    typedef struct packed {
        logic        header_ok;
        logic [31:0] image_width;
        logic [31:0] image_height;
    } result_item_t;

    // Eight-byte PNG file signature.
    localparam logic [7:0] PNG_SIG [8] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    // Chunk type of the first chunk: "IHDR".
    localparam logic [7:0] IHDR_TAG [4] = '{8'h49, 8'h48, 8'h44, 8'h52};

    // Smallest legal IHDR data length.
    localparam logic [31:0] MIN_IHDR_LEN = 32'd13;

    // Bytes in front of the IHDR data: signature, length and tag.
    localparam int unsigned HDR_OVERHEAD = 16;

endpackage

### src/png_header_size_parser.sv
// ----------------------------------------------------------------------------
// PNG header size parser
// Checks the PNG signature and IHDR tag of a byte stream and reports the
// image width and height on the last byte of each file.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   byte      in         byte_valid / byte_stall    byte_item   (byte_item_t)
//   result    out        result_valid / result_stall result_item (result_item_t)
//
// One byte is accepted every cycle while byte_stall is low. A result is
// given on result_item from the output register.
// A skid register behind the output register lets one more result collect
// while the output is stalled; byte_stall is raised only while that skid
// register is full.
// Reset clears the byte counter and the field registers, sets the match flags and clears both result valid bits.
// ----------------------------------------------------------------------------
module png_header_size_parser
    import png_hdr_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 34
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  byte_item_t   byte_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    // Parse state for the current file.
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  sig_ok_reg, sig_ok_next;
    logic                  tag_ok_reg, tag_ok_next;
    logic [31:0]           length_reg, length_next;
    logic [31:0]           width_reg, width_next;
    logic [31:0]           height_reg, height_next;

    // Output register and skid register.
    logic         out_valid_reg;
    result_item_t out_item_reg;
    logic         skid_valid_reg;
    result_item_t skid_item_reg;

    logic                  byte_fire;
    logic                  result_fire;
    logic                  out_free;
    logic                  new_result;
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] needed;
    logic                  header_ok;
    result_item_t          result_new;
    logic                  in_sig;
    logic                  in_length;
    logic                  in_tag;
    logic                  in_width;
    logic                  in_height;

    // Handshake.
    assign byte_stall   = skid_valid_reg;
    assign byte_fire    = byte_valid && !byte_stall;
    assign result_fire  = out_valid_reg && !result_stall;
    assign out_free     = !out_valid_reg || result_fire;
    assign new_result   = byte_fire && byte_item.last_byte;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    // Decode which header field the current byte belongs to.
    always_comb
    begin
        in_sig    = (count_reg[COUNT_BITS-1:3] == '0);
        in_length = (count_reg[COUNT_BITS-1:4] == '0) && (count_reg[3:2] == 2'b10);
        in_tag    = (count_reg[COUNT_BITS-1:4] == '0) && (count_reg[3:2] == 2'b11);
        in_width  = (count_reg[COUNT_BITS-1:5] == '0) && (count_reg[4:2] == 3'b100);
        in_height = (count_reg[COUNT_BITS-1:5] == '0) && (count_reg[4:2] == 3'b101);
    end

    // Field updates and the saturating byte count, this byte included.
    always_comb
    begin
        sig_ok_next = sig_ok_reg;
        tag_ok_next = tag_ok_reg;
        length_next = length_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (in_sig && (byte_item.data_byte != PNG_SIG[count_reg[2:0]]))
        begin
            sig_ok_next = 1'b0;
        end
        if (in_length)
        begin
            length_next = {length_reg[23:0], byte_item.data_byte};
        end
        if (in_tag && (byte_item.data_byte != IHDR_TAG[count_reg[1:0]]))
        begin
            tag_ok_next = 1'b0;
        end
        if (in_width)
        begin
            width_next = {width_reg[23:0], byte_item.data_byte};
        end
        if (in_height)
        begin
            height_next = {height_reg[23:0], byte_item.data_byte};
        end
        total = (count_reg == '1) ? count_reg : count_reg + COUNT_BITS'(1);
        count_next = total;
    end

    // Result for a file that ends with this byte.
    always_comb
    begin
        needed    = COUNT_BITS'(length_next) + COUNT_BITS'(HDR_OVERHEAD);
        header_ok = sig_ok_next && tag_ok_next && (length_next >= MIN_IHDR_LEN)
                    && (total >= needed);
        result_new.header_ok    = header_ok;
        result_new.image_width  = header_ok ? width_next : 32'd0;
        result_new.image_height = header_ok ? height_next : 32'd0;
    end

    // Parse state: advance on every byte, return to reset after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sig_ok_reg <= 1'b1;
            tag_ok_reg <= 1'b1;
            length_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (byte_fire)
        begin
            if (byte_item.last_byte)
            begin
                count_reg  <= '0;
                sig_ok_reg <= 1'b1;
                tag_ok_reg <= 1'b1;
                length_reg <= '0;
                width_reg  <= '0;
                height_reg <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                sig_ok_reg <= sig_ok_next;
                tag_ok_reg <= tag_ok_next;
                length_reg <= length_next;
                width_reg  <= width_next;
                height_reg <= height_next;
            end
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= new_result;
            end
        end
        else if (new_result)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payloads.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg <= skid_item_reg;
            end
            else if (new_result)
            begin
                out_item_reg <= result_new;
            end
        end
        else if (new_result)
        begin
            skid_item_reg <= result_new;
        end
    end

endmodule

### bench/png_header_checker.sv
// ----------------------------------------------------------------------------
// PNG header checker
// Watches the byte and result channels of the PNG header size parser. It
// parses every accepted byte request with its own copy of the header state,
// queues the header result that each last byte calls for, and compares every
// accepted result with the oldest queued one.
// ----------------------------------------------------------------------------
module png_header_checker
    import png_hdr_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 34
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    input  logic         byte_stall,
    input  byte_item_t   byte_item,
    input  logic         result_valid,
    input  logic         result_stall,
    input  result_item_t result_item,
    output int           fail_count,
    output int           pending_count
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Parse state of the file in progress.
    logic [COUNT_BITS-1:0] bytes_seen;
    logic                  sig_good;
    logic                  tag_good;
    logic [31:0]           ihdr_length;
    logic [31:0]           width_acc;
    logic [31:0]           height_acc;

    // Header results still owed by the parser, oldest first.
    result_item_t          owed_headers[$];

    task report_mismatch(input string what);
        $display("[%0t] header mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Add a header result at the tail of the owed list.
    task owe_header(input result_item_t hdr);
        owed_headers.insert(owed_headers.size(), hdr);
    endtask

    // Return to the state at the start of a file.
    task clear_parse();
        bytes_seen  = '0;
        sig_good    = 1'b1;
        tag_good    = 1'b1;
        ihdr_length = '0;
        width_acc   = '0;
        height_acc  = '0;
    endtask

    // Take one byte request; on the last byte of a file queue its header result.
    task parse_byte(input byte_item_t req);
        logic [COUNT_BITS-1:0] offset;
        logic [63:0]           total;
        result_item_t          hdr;
        offset = bytes_seen;
        if (offset < 8)
        begin
            if (req.data_byte != PNG_SIG[offset[2:0]])
                sig_good = 1'b0;
        end
        else if (offset < 12)
            ihdr_length = {ihdr_length[23:0], req.data_byte};
        else if (offset < 16)
        begin
            if (req.data_byte != IHDR_TAG[offset[1:0]])
                tag_good = 1'b0;
        end
        else if (offset < 20)
            width_acc = {width_acc[23:0], req.data_byte};
        else if (offset < 24)
            height_acc = {height_acc[23:0], req.data_byte};

        // The byte count sticks at its maximum on very long files.
        if (offset != COUNT_MAX)
            bytes_seen = offset + 1'b1;

        if (req.last_byte)
        begin
            // The length test is done at full width so that it cannot wrap.
            total = 64'(bytes_seen);
            hdr.header_ok = sig_good && tag_good && (ihdr_length >= MIN_IHDR_LEN)
                && (total >= 64'(ihdr_length) + 64'(HDR_OVERHEAD));
            hdr.image_width  = hdr.header_ok ? width_acc  : '0;
            hdr.image_height = hdr.header_ok ? height_acc : '0;
            owe_header(hdr);
            clear_parse();
        end
    endtask

    // Compare one accepted result with the oldest owed header.
    task check_result(input result_item_t got);
        result_item_t want;
        if (owed_headers.size() == 0)
        begin
            report_mismatch("result request with no header owed");
            return;
        end
        want = owed_headers.pop_front();
        if (got.header_ok !== want.header_ok)
            report_mismatch($sformatf("header_ok got %b want %b",
                got.header_ok, want.header_ok));
        if (got.image_width !== want.image_width)
            report_mismatch($sformatf("image_width got %h want %h",
                got.image_width, want.image_width));
        if (got.image_height !== want.image_height)
            report_mismatch($sformatf("image_height got %h want %h",
                got.image_height, want.image_height));
    endtask

    // Results are checked before the byte of the same edge is parsed, since a
    // result can only come from a byte taken at an earlier edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            owed_headers.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result_item);
            if (byte_valid && !byte_stall)
                parse_byte(byte_item);
            pending_count = owed_headers.size();
        end
    end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// PNG header size parser testbench
// Sends a few directed files and then random files, mostly well-formed
// headers with random dimensions and lengths around the legal limit, mixed
// with corrupted, short and noise files. Both sides idle at random, and once
// the result side holds off long enough to back up the byte input. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import png_hdr_pkg::*;

    localparam int unsigned COUNT_BITS   = 34;
    localparam int unsigned ITEM_TARGET  = 1250;
    localparam int unsigned HOLD_AFTER   = 400;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic         clk;
    logic         rst_n;
    logic         byte_valid;
    logic         byte_stall;
    byte_item_t   byte_item;
    logic         result_valid;
    logic         result_stall;
    result_item_t result_item;

    logic         random_stall = 1'b0;
    logic         long_hold    = 1'b0;
    logic         tx_calm      = 1'b0;
    int unsigned  sent_count   = 0;
    int unsigned  cycle_count  = 0;
    int           fail_count;
    int           pending_count;
    logic [7:0]   file_bytes[$];

    assign result_stall = random_stall | long_hold;

    png_header_size_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    png_header_checker #(
        .COUNT_BITS (COUNT_BITS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_item     (byte_item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_item   (result_item),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one byte request after a random gap and wait until it is taken.
    task send_byte(input logic [7:0] data, input logic last);
        int unsigned gap;
        gap = (tx_calm || long_hold) ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= '{data_byte: data, last_byte: last};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // Append one byte to the file being built.
    task add_byte(input logic [7:0] value);
        file_bytes.insert(file_bytes.size(), value);
    endtask

    task send_file();
        int k;
        for (k = 0; k < file_bytes.size(); k++)
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
    endtask

    // Build a random file: mostly well-formed headers, some with a bad
    // signature or tag byte, short files, noise, and odd chunk lengths.
    task make_random_file();
        int unsigned kind;
        int unsigned total;
        int          k;
        logic [31:0] chunk_len;
        kind = $urandom_range(0, 9);
        file_bytes.delete();
        if (kind == 8)
        begin
            total = $urandom_range(1, 40);
            repeat (total) add_byte(8'($urandom));
            return;
        end
        chunk_len = $urandom_range(13, 20);
        if (kind == 9)
        begin
            if ($urandom_range(0, 1) == 0)
                chunk_len = $urandom_range(0, 12);
            else if ($urandom_range(0, 1) == 0)
                chunk_len = 32'hFFFF_FFFF;
            else
                chunk_len = $urandom;
        end
        for (k = 0; k < 8; k++)
            add_byte(PNG_SIG[k]);
        for (k = 0; k < 4; k++)
            add_byte(chunk_len[31 - 8 * k -: 8]);
        for (k = 0; k < 4; k++)
            add_byte(IHDR_TAG[k]);
        repeat (8) add_byte(8'($urandom));

        // Flip one bit in a signature or tag byte.
        if (kind == 6)
        begin
            k = $urandom_range(0, 11);
            if (k >= 8)
                k += 4;
            file_bytes[k] = file_bytes[k] ^ (8'd1 << $urandom_range(0, 7));
        end

        // File length lands just around the chunk end unless the file is short or the chunk is long.
        if (kind == 7)
            total = $urandom_range(1, 24);
        else if (chunk_len > 40)
            total = $urandom_range(24, 48);
        else
            total = chunk_len + 16 + $urandom_range(0, 6) - 3;
        while (file_bytes.size() > total)
            void'(file_bytes.pop_back());
        while (file_bytes.size() < total)
            add_byte(8'($urandom));
    endtask

    // Stimulus and verdict.
    initial
    begin
        int k;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_item  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A one-byte file fails the length test.
        file_bytes = {8'h00};
        send_file();

        // Smallest legal file with the widest width and zero height, plus
        // bytes past the dimensions that are only counted.
        file_bytes.delete();
        for (k = 0; k < 8; k++)
            add_byte(PNG_SIG[k]);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h0D);
        for (k = 0; k < 4; k++)
            add_byte(IHDR_TAG[k]);
        repeat (4) add_byte(8'hFF);
        repeat (4) add_byte(8'h00);
        repeat (5) add_byte(8'hA5);
        send_file();

        while (sent_count < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                tx_calm = !tx_calm;
            make_random_file();
            send_file();
        end
        byte_valid <= 1'b0;

        // Let the checker see the last byte before waiting on it.
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Result side: a random stall after each taken result, with calm stretches.
    initial
    begin
        int unsigned n;
        logic        rx_calm;
        rx_calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                if ($urandom_range(0, 15) == 0)
                    rx_calm = !rx_calm;
                n = rx_calm ? 0 : $urandom_range(0, 18);
                if (n != 0)
                begin
                    random_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    random_stall <= 1'b0;
                end
            end
        end
    end

    // One long hold on the result side while bytes keep coming back to back.
    initial
    begin
        int unsigned n;
        wait (sent_count >= HOLD_AFTER);
        @(posedge clk);
        long_hold <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++)
            @(posedge clk);
        long_hold <= 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

endmodule

### sim.f
src/png_hdr_pkg.sv
src/png_header_size_parser.sv
bench/png_header_checker.sv
bench/testbench.sv
